FILE: rtl/ssui_pkg.sv
// ----------------------------------------------------------------------------
// ssui_pkg
// Shared types and constants for the sorted set union / intersection engine.
// ----------------------------------------------------------------------------
package ssui_pkg;

  localparam int DATA_W        = 32;
  localparam int KIND_W        = 3;
  localparam int DEPTH_DEFAULT = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_A    = 3'd0,
    KIND_LOAD_B    = 3'd1,
    KIND_UNION     = 3'd2,
    KIND_INTERSECT = 3'd3,
    KIND_CLEAR     = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic go;
    logic is_union;
  } run_cmd_t;

endpackage

FILE: rtl/ssui_ram.sv
// ----------------------------------------------------------------------------
// ssui_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ssui_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/ssui_merge.sv
// ----------------------------------------------------------------------------
// ssui_merge
// Two-pointer merge walk over both list memories. One pointer step per
// cycle; each emitted element is held back until the next step that emits,
// or the finish, so the final one can be tagged last.
// ----------------------------------------------------------------------------
module ssui_merge #(
  parameter int  DEPTH = ssui_pkg::DEPTH_DEFAULT,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ssui_pkg::run_cmd_t                 cmd,
  input  logic [CW-1:0]                      count_a,
  input  logic [CW-1:0]                      count_b,
  input  logic                               dropped,
  input  logic signed [ssui_pkg::DATA_W-1:0] rd_a,
  input  logic signed [ssui_pkg::DATA_W-1:0] rd_b,
  output logic [AW-1:0]                      raddr_a,
  output logic [AW-1:0]                      raddr_b,
  output logic                               busy,
  output logic                               strobe,
  output logic signed [ssui_pkg::DATA_W-1:0] value_out,
  output logic                               none,
  output logic                               last,
  output logic                               overflow
);

  ssui_pkg::state_t state, state_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] j, j_next;
  logic signed [ssui_pkg::DATA_W-1:0] pend, pend_next;
  logic pend_vld, pend_vld_next;
  logic mode_union, mode_union_next;
  logic emit, fin, a_ok, b_ok;
  logic signed [ssui_pkg::DATA_W-1:0] emit_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ssui_pkg::ST_IDLE;
      pend_vld <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      state    <= state_next;
      pend_vld <= pend_vld_next;
      strobe   <= (emit && pend_vld) || fin;
    end
  end

  always_ff @(posedge clk) begin
    i          <= i_next;
    j          <= j_next;
    pend       <= pend_next;
    mode_union <= mode_union_next;
    value_out  <= (fin && !pend_vld) ? '0 : pend;
    none       <= fin && !pend_vld;
    last       <= fin;
    overflow   <= dropped;
  end

  assign busy = (state != ssui_pkg::ST_IDLE);

  always_comb begin
    state_next      = state;
    i_next          = i;
    j_next          = j;
    pend_next       = pend;
    pend_vld_next   = pend_vld;
    mode_union_next = mode_union;
    emit            = 1'b0;
    emit_val        = rd_a;
    fin             = 1'b0;
    raddr_a         = '0;
    raddr_b         = '0;
    a_ok            = (i < count_a);
    b_ok            = (j < count_b);
    case (state)
      ssui_pkg::ST_IDLE: begin
        if (cmd.go) begin
          i_next          = '0;
          j_next          = '0;
          pend_vld_next   = 1'b0;
          mode_union_next = cmd.is_union;
          state_next      = ssui_pkg::ST_WALK;
        end
      end
      ssui_pkg::ST_WALK: begin
        if (a_ok && b_ok) begin
          if (rd_a < rd_b) begin
            emit     = mode_union;
            emit_val = rd_a;
            i_next   = i + CW'(1);
          end else if (rd_b < rd_a) begin
            emit     = mode_union;
            emit_val = rd_b;
            j_next   = j + CW'(1);
          end else begin
            emit     = 1'b1;
            emit_val = rd_a;
            i_next   = i + CW'(1);
            j_next   = j + CW'(1);
          end
        end else if (mode_union && b_ok) begin
          emit     = 1'b1;
          emit_val = rd_b;
          j_next   = j + CW'(1);
        end else if (mode_union && a_ok) begin
          emit     = 1'b1;
          emit_val = rd_a;
          i_next   = i + CW'(1);
        end else begin
          state_next = ssui_pkg::ST_FINISH;
        end
        if (emit) begin
          pend_next     = emit_val;
          pend_vld_next = 1'b1;
        end
        raddr_a = i_next[AW-1:0];
        raddr_b = j_next[AW-1:0];
      end
      ssui_pkg::ST_FINISH: begin
        fin        = 1'b1;
        state_next = ssui_pkg::ST_IDLE;
      end
      default: begin
        state_next = ssui_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/sorted_set_union_intersection.sv
// ----------------------------------------------------------------------------
// sorted_set_union_intersection
// Sorted list union / intersection engine over two list memories.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low; kind selects
//   load A, load B, run union, run intersection or clear, and value carries
//   the element for loads.
//   Loads and clear never raise busy; a load into a full
//   list is dropped and sets the sticky overflow flag until the next clear.
//   A run raises busy through the walk and the finish state; the walk takes
//   at most count_a + count_b pointer steps: one step per cycle, set by the
//   single read port of each list memory feeding the compare.
//   Results appear on value_out/none/last/overflow for one cycle each, marked
//   by strobe; each element is shown the cycle after the next step that
//   emits, and the final one (last) is shown in the same cycle that busy drops.
//   An empty answer gives a single result with none and last set.
//   The receiver has no way to stall results.
//   Reset empties both lists and clears overflow; memory contents are not
//   cleared, no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_set_union_intersection #(
  parameter int DEPTH = ssui_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [ssui_pkg::KIND_W-1:0]        kind,
  input  logic signed [ssui_pkg::DATA_W-1:0] value,
  output logic                               strobe,
  output logic signed [ssui_pkg::DATA_W-1:0] value_out,
  output logic                               none,
  output logic                               last,
  output logic                               overflow
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_a, count_a_next;
  logic [CW-1:0] count_b, count_b_next;
  logic dropped, dropped_next;
  logic accept, we_a, we_b;
  logic [AW-1:0] raddr_a, raddr_b;
  logic [ssui_pkg::DATA_W-1:0] rdata_a, rdata_b;
  ssui_pkg::run_cmd_t cmd;

  assign accept = start && !busy;

  always_comb begin
    count_a_next = count_a;
    count_b_next = count_b;
    dropped_next = dropped;
    we_a         = 1'b0;
    we_b         = 1'b0;
    cmd.go       = 1'b0;
    cmd.is_union = 1'b0;
    if (accept) begin
      case (kind)
        ssui_pkg::KIND_LOAD_A: begin
          if (count_a < CW'(DEPTH)) begin
            we_a         = 1'b1;
            count_a_next = count_a + CW'(1);
          end else begin
            dropped_next = 1'b1;
          end
        end
        ssui_pkg::KIND_LOAD_B: begin
          if (count_b < CW'(DEPTH)) begin
            we_b         = 1'b1;
            count_b_next = count_b + CW'(1);
          end else begin
            dropped_next = 1'b1;
          end
        end
        ssui_pkg::KIND_UNION: begin
          cmd.go       = 1'b1;
          cmd.is_union = 1'b1;
        end
        ssui_pkg::KIND_INTERSECT: begin
          cmd.go = 1'b1;
        end
        ssui_pkg::KIND_CLEAR: begin
          count_a_next = '0;
          count_b_next = '0;
          dropped_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a <= '0;
      count_b <= '0;
      dropped <= 1'b0;
    end else begin
      count_a <= count_a_next;
      count_b <= count_b_next;
      dropped <= dropped_next;
    end
  end

  ssui_ram #(
    .WIDTH (ssui_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (count_a[AW-1:0]),
    .wdata (value),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  ssui_ram #(
    .WIDTH (ssui_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (count_b[AW-1:0]),
    .wdata (value),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  ssui_merge #(
    .DEPTH (DEPTH)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .count_a   (count_a),
    .count_b   (count_b),
    .dropped   (dropped),
    .rd_a      ($signed(rdata_a)),
    .rd_b      ($signed(rdata_b)),
    .raddr_a   (raddr_a),
    .raddr_b   (raddr_b),
    .busy      (busy),
    .strobe    (strobe),
    .value_out (value_out),
    .none      (none),
    .last      (last),
    .overflow  (overflow)
  );

  a_none_is_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && none) |-> last)
    else $error("empty result not marked last");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && none) |-> (value_out == '0))
    else $error("empty result carries a value");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == ssui_pkg::KIND_UNION || kind == ssui_pkg::KIND_INTERSECT))
      |=> busy)
    else $error("run transaction did not raise busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count_a <= CW'(DEPTH)) && (count_b <= CW'(DEPTH)))
    else $error("list count beyond depth");

endmodule
